// ===== hdl/tti_pkg.sv =====
// Package for the table time interpolator: widths, request and register codes,
// the stored entry format and the divider request/response types.
// Depends on nothing; every other file in hdl imports it.
package tti_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths.
    localparam int REQ_W  = 2;
    localparam int TIME_W = 32;
    localparam int WIND_W = 16;
    localparam int QT_W   = 31;
    localparam int OFS_W  = 31;

    // Datapath widths: query time plus offset, time differences and magnitudes.
    localparam int T_W    = QT_W + 2;
    localparam int NUM_W  = T_W + 1;
    localparam int MAG_W  = NUM_W - 1;
    localparam int DW_W   = WIND_W + 1;
    localparam int PROD_W = WIND_W + MAG_W;
    localparam int DVD_W  = PROD_W;
    localparam int DVS_W  = TIME_W;
    localparam int QS_W   = DVD_W + 1;
    localparam int SUM_W  = QS_W + 1;

    // Iteration counters of the serial units.
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam int MUL_CNT_W = $clog2(MAG_W);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = OFS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'd1;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [TIME_W-1:0] tm;
        logic [WIND_W-1:0] wn;
        logic [WIND_W-1:0] we;
    } entry_t;

    // Request to the serial divider.
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    // Response of the serial divider.
    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== hdl/tti_div.sv =====
// Bit-serial restoring divider for unsigned operands, one quotient bit per cycle.
// Depends on tti_pkg for its widths and request/response types.
module tti_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tti_pkg::div_req_t req,
    output tti_pkg::div_rsp_t rsp
);
    import tti_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]     quo_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;

    logic [DVS_W:0]       shifted;
    logic [DVS_W:0]       trial;
    logic                 fits;
    logic [DVS_W-1:0]     rem_next;
    logic [DVD_W-1:0]     quo_next;

    // One restoring step: bring in the next dividend bit and try the divisor.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DVD_W-1]};
        trial    = shifted - {1'b0, dvs_reg};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], fits};
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and result shift registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hdl/table_time_interpolator.sv =====
// Top level of the table time interpolator: entry memory, search sequencer,
// serial multiplier and the two lane dividers.
// Depends on tti_pkg and tti_div.
//
// Usage. The input channel (in_valid/in_ready) carries one request per beat:
// clear the table, append an entry, or query the wind at a time. The output
// channel (out_valid/out_ready) carries one result beat per query and nothing
// for clear, append or an unknown code. Registers loop_enable and time_offset
// are written over the cfg channel, which is always ready.
// A clear or an append leaves the sequencer idle, so the block stays ready.
// A query with fewer than two entries goes straight to the output; one that is
// clamped at either end first reads both end entries. A query that interpolates
// also runs a binary search over the read port of the entry memory, then a
// shift-add multiplier and a restoring divider per wind lane, the two lanes run
// in parallel. Loop mode adds a modulo, which runs on the north lane divider.
// Reset empties the table and clears both registers; memory contents are kept.
// The finished result sits in an output register; while the receiver stalls
// the block still takes clears and appends, and a new query waits at the end
// of its work until the output register is free.
module table_time_interpolator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic        [tti_pkg::REQ_W-1:0]  req_type,
    input  logic signed [tti_pkg::TIME_W-1:0] entry_time,
    input  logic signed [tti_pkg::WIND_W-1:0] entry_wind_n,
    input  logic signed [tti_pkg::WIND_W-1:0] entry_wind_e,
    input  logic        [tti_pkg::QT_W-1:0]   query_time,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [tti_pkg::WIND_W-1:0] wind_n,
    output logic signed [tti_pkg::WIND_W-1:0] wind_e,
    output logic                             table_ready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tti_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tti_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tti_pkg::*;

    // Sequencer states.
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_FIRST  = 5'd1;
    localparam logic [4:0] S_LAST   = 5'd2;
    localparam logic [4:0] S_DECIDE = 5'd3;
    localparam logic [4:0] S_MODGO  = 5'd4;
    localparam logic [4:0] S_MOD    = 5'd5;
    localparam logic [4:0] S_SRCH   = 5'd6;
    localparam logic [4:0] S_CMP    = 5'd7;
    localparam logic [4:0] S_RDA    = 5'd8;
    localparam logic [4:0] S_RDB    = 5'd9;
    localparam logic [4:0] S_ABS    = 5'd10;
    localparam logic [4:0] S_MUL    = 5'd11;
    localparam logic [4:0] S_DIVGO  = 5'd12;
    localparam logic [4:0] S_DIV    = 5'd13;
    localparam logic [4:0] S_FIN    = 5'd14;
    localparam logic [4:0] S_OUT    = 5'd15;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'sd1 <<< (WIND_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    // One step of the right-shifting multiplier: add the multiplicand into the
    // upper half when the low multiplier bit is set, then shift right.
    function automatic logic [PROD_W-1:0] mul_step(input logic [PROD_W-1:0] p,
                                                   input logic [WIND_W-1:0] mc);
        logic [WIND_W:0] upper;
        upper = {1'b0, p[PROD_W-1:MAG_W]} + (p[0] ? {1'b0, mc} : {(WIND_W + 1){1'b0}});
        return {upper, p[MAG_W-1:1]};
    endfunction

    // Saturate a wide signed sum to the wind range.
    function automatic logic [WIND_W-1:0] sat_wind(input logic signed [SUM_W-1:0] v);
        logic [WIND_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[WIND_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[WIND_W-1:0];
        else
            r = v[WIND_W-1:0];
        return r;
    endfunction

    // Control state.
    logic [4:0]           state_reg;
    logic [4:0]           state_next;
    logic [CNT_W-1:0]     count_reg;
    logic                 out_valid_reg;
    logic                 loop_reg;
    logic signed [OFS_W-1:0] ofs_reg;

    // Entry memory.
    entry_t               mem [TABLE_DEPTH];
    entry_t               rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;

    // Datapath registers.
    logic signed [T_W-1:0]    t_reg;
    logic signed [T_W-1:0]    span_reg;
    logic signed [T_W-1:0]    den_reg;
    logic signed [TIME_W-1:0] ts_reg;
    logic signed [TIME_W-1:0] te_reg;
    logic signed [TIME_W-1:0] t1_reg;
    logic signed [NUM_W-1:0]  d_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic signed [WIND_W-1:0] w0n_reg;
    logic signed [WIND_W-1:0] w0e_reg;
    logic signed [WIND_W-1:0] wln_reg;
    logic signed [WIND_W-1:0] wle_reg;
    logic signed [WIND_W-1:0] w1n_reg;
    logic signed [WIND_W-1:0] w1e_reg;
    logic signed [DW_W-1:0]   dwn_reg;
    logic signed [DW_W-1:0]   dwe_reg;
    logic [PROD_W-1:0]        pn_reg;
    logic [PROD_W-1:0]        pe_reg;
    logic [WIND_W-1:0]        mcn_reg;
    logic [WIND_W-1:0]        mce_reg;
    logic                     sgn_n_reg;
    logic                     sgn_e_reg;
    logic [DVS_W-1:0]         dvs_reg;
    logic [MUL_CNT_W-1:0]     mul_cnt_reg;
    logic signed [QS_W-1:0]   qn_reg;
    logic signed [QS_W-1:0]   qe_reg;
    logic [CNT_W-1:0]         lo_reg;
    logic [CNT_W-1:0]         hi_reg;
    logic [CNT_W-1:0]         mid_reg;
    logic [WIND_W-1:0]        res_n_reg;
    logic [WIND_W-1:0]        res_e_reg;
    logic                     res_rdy_reg;
    logic [WIND_W-1:0]        wind_n_reg;
    logic [WIND_W-1:0]        wind_e_reg;
    logic                     table_ready_reg;

    // Combinational helpers.
    logic                     in_accept;
    logic                     out_load;
    logic signed [TIME_W-1:0] rd_tm;
    logic signed [WIND_W-1:0] rd_wn;
    logic signed [WIND_W-1:0] rd_we;
    logic [CNT_W-1:0]         last_cnt;
    logic [CNT_W-1:0]         prev_cnt;
    logic [CNT_W-1:0]         mid;
    logic                     loop_go;
    logic                     clamp_lo;
    logic                     clamp_hi;
    logic [NUM_W-1:0]         d_neg;
    logic [MAG_W-1:0]         d_mag;
    logic [NUM_W-1:0]         num_neg;
    logic [MAG_W-1:0]         num_mag;
    logic [DW_W-1:0]          dwn_neg;
    logic [DW_W-1:0]          dwe_neg;
    logic [WIND_W-1:0]        dwn_mag;
    logic [WIND_W-1:0]        dwe_mag;
    logic                     den_pos;
    logic signed [T_W-1:0]    rem_wide;
    logic                     wrap_neg;
    logic [QS_W-1:0]          qmag_n;
    logic [QS_W-1:0]          qmag_e;
    logic [QS_W-1:0]          qneg_n;
    logic [QS_W-1:0]          qneg_e;
    logic signed [SUM_W-1:0]  sum_n;
    logic signed [SUM_W-1:0]  sum_e;
    div_req_t                 req_n;
    div_req_t                 req_e;
    div_rsp_t                 rsp_n;
    div_rsp_t                 rsp_e;

    // Handshakes.
    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign mem_we    = in_accept && (req_type == REQ_APPEND)
                       && (count_reg < CNT_W'(TABLE_DEPTH));

    // Read data fields and search arithmetic.
    assign rd_tm    = rd_data_reg.tm;
    assign rd_wn    = rd_data_reg.wn;
    assign rd_we    = rd_data_reg.we;
    assign last_cnt = count_reg - CNT_W'(1);
    assign prev_cnt = lo_reg - CNT_W'(1);
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);

    // Mode decision after both end entries are known.
    assign loop_go  = loop_reg && !span_reg[T_W-1] && (span_reg != '0);
    assign clamp_lo = t_reg <= T_W'(ts_reg);
    assign clamp_hi = t_reg >= T_W'(te_reg);

    // Magnitudes and signs for the serial units.
    assign d_neg    = -d_reg;
    assign d_mag    = d_reg[NUM_W-1] ? d_neg[MAG_W-1:0] : d_reg[MAG_W-1:0];
    assign num_neg  = -num_reg;
    assign num_mag  = num_reg[NUM_W-1] ? num_neg[MAG_W-1:0] : num_reg[MAG_W-1:0];
    assign dwn_neg  = -dwn_reg;
    assign dwe_neg  = -dwe_reg;
    assign dwn_mag  = dwn_reg[DW_W-1] ? dwn_neg[WIND_W-1:0] : dwn_reg[WIND_W-1:0];
    assign dwe_mag  = dwe_reg[DW_W-1] ? dwe_neg[WIND_W-1:0] : dwe_reg[WIND_W-1:0];
    assign den_pos  = !den_reg[T_W-1] && (den_reg != '0);

    // Wrapped time: a time before the first entry with a nonzero remainder folds back from the end.
    assign rem_wide = $signed({1'b0, rsp_n.remainder});
    assign wrap_neg = d_reg[NUM_W-1] && (rsp_n.remainder != '0);

    // Signed quotients and the final sums.
    assign qmag_n = {1'b0, rsp_n.quotient};
    assign qmag_e = {1'b0, rsp_e.quotient};
    assign qneg_n = -qmag_n;
    assign qneg_e = -qmag_e;
    assign sum_n  = SUM_W'(w1n_reg) + SUM_W'(qn_reg);
    assign sum_e  = SUM_W'(w1e_reg) + SUM_W'(qe_reg);

    // Divider requests: the north lane also serves the loop-mode modulo.
    always_comb
    begin
        req_n.start    = (state_reg == S_MODGO) || (state_reg == S_DIVGO);
        req_n.dividend = (state_reg == S_MODGO) ? DVD_W'(d_mag) : pn_reg;
        req_n.divisor  = (state_reg == S_MODGO) ? span_reg[DVS_W-1:0] : dvs_reg;
        req_e.start    = (state_reg == S_DIVGO);
        req_e.dividend = pe_reg;
        req_e.divisor  = dvs_reg;
    end

    tti_div u_div_n (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_n),
        .rsp   (rsp_n)
    );

    tti_div u_div_e (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_e),
        .rsp   (rsp_e)
    );

    // Memory read address for the next cycle.
    always_comb
    begin
        case (state_reg)
            S_IDLE:  rd_addr = '0;
            S_FIRST: rd_addr = last_cnt[IDX_W-1:0];
            S_SRCH:  rd_addr = (lo_reg < hi_reg) ? mid[IDX_W-1:0] : prev_cnt[IDX_W-1:0];
            S_RDA:   rd_addr = lo_reg[IDX_W-1:0];
            default: rd_addr = '0;
        endcase
    end

    // Entry memory: one write port for appends, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[IDX_W-1:0]] <= entry_t'({entry_time, entry_wind_n, entry_wind_e});
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (req_type == REQ_QUERY))
                    state_next = (count_reg < CNT_W'(2)) ? S_OUT : S_FIRST;
            end
            S_FIRST:  state_next = S_LAST;
            S_LAST:   state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (loop_go)
                    state_next = S_MODGO;
                else if (clamp_lo || clamp_hi)
                    state_next = S_OUT;
                else
                    state_next = S_SRCH;
            end
            S_MODGO:  state_next = S_MOD;
            S_MOD:
            begin
                if (rsp_n.done)
                    state_next = S_SRCH;
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                    state_next = S_CMP;
                else if ((lo_reg == '0) || (lo_reg >= count_reg))
                    state_next = S_OUT;
                else
                    state_next = S_RDA;
            end
            S_CMP:    state_next = S_SRCH;
            S_RDA:    state_next = S_RDB;
            S_RDB:    state_next = S_ABS;
            S_ABS:    state_next = S_MUL;
            S_MUL:
            begin
                if (mul_cnt_reg == MUL_CNT_W'(MAG_W - 1))
                    state_next = S_DIVGO;
            end
            S_DIVGO:  state_next = S_DIV;
            S_DIV:
            begin
                if (rsp_n.done)
                    state_next = S_FIN;
            end
            S_FIN:    state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers: state, entry count, output valid and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            loop_reg      <= 1'b0;
            ofs_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_accept && (req_type == REQ_CLEAR))
                count_reg <= '0;
            else if (mem_we)
                count_reg <= count_reg + CNT_W'(1);

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_LOOP:   loop_reg <= cfg_data[0];
                    CFG_OFFSET: ofs_reg  <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (req_type == REQ_QUERY))
                begin
                    t_reg       <= $signed({2'b00, query_time}) + T_W'(ofs_reg);
                    res_n_reg   <= '0;
                    res_e_reg   <= '0;
                    res_rdy_reg <= (count_reg >= CNT_W'(2));
                end
            end
            S_FIRST:
            begin
                ts_reg  <= rd_tm;
                w0n_reg <= rd_wn;
                w0e_reg <= rd_we;
            end
            S_LAST:
            begin
                te_reg   <= rd_tm;
                wln_reg  <= rd_wn;
                wle_reg  <= rd_we;
                span_reg <= T_W'(rd_tm) - T_W'(ts_reg);
            end
            S_DECIDE:
            begin
                d_reg  <= NUM_W'(t_reg) - NUM_W'(ts_reg);
                lo_reg <= '0;
                hi_reg <= count_reg;
                if (!loop_go && clamp_lo)
                begin
                    res_n_reg <= w0n_reg;
                    res_e_reg <= w0e_reg;
                end
                else if (!loop_go && clamp_hi)
                begin
                    res_n_reg <= wln_reg;
                    res_e_reg <= wle_reg;
                end
            end
            S_MOD:
            begin
                if (rsp_n.done)
                    t_reg <= wrap_neg ? T_W'(te_reg) - rem_wide : T_W'(ts_reg) + rem_wide;
            end
            S_SRCH:
            begin
                mid_reg <= mid;
                if ((lo_reg >= hi_reg) && (lo_reg == '0))
                begin
                    res_n_reg <= w0n_reg;
                    res_e_reg <= w0e_reg;
                end
                else if ((lo_reg >= hi_reg) && (lo_reg >= count_reg))
                begin
                    res_n_reg <= wln_reg;
                    res_e_reg <= wle_reg;
                end
            end
            S_CMP:
            begin
                if (T_W'(rd_tm) < t_reg)
                    lo_reg <= mid_reg + CNT_W'(1);
                else
                    hi_reg <= mid_reg;
            end
            S_RDA:
            begin
                t1_reg  <= rd_tm;
                w1n_reg <= rd_wn;
                w1e_reg <= rd_we;
            end
            S_RDB:
            begin
                den_reg <= T_W'(rd_tm) - T_W'(t1_reg);
                num_reg <= NUM_W'(t_reg) - NUM_W'(t1_reg);
                dwn_reg <= DW_W'(rd_wn) - DW_W'(w1n_reg);
                dwe_reg <= DW_W'(rd_we) - DW_W'(w1e_reg);
            end
            S_ABS:
            begin
                pn_reg      <= {{WIND_W{1'b0}}, num_mag};
                pe_reg      <= {{WIND_W{1'b0}}, num_mag};
                mcn_reg     <= dwn_mag;
                mce_reg     <= dwe_mag;
                sgn_n_reg   <= num_reg[NUM_W-1] ^ dwn_reg[DW_W-1];
                sgn_e_reg   <= num_reg[NUM_W-1] ^ dwe_reg[DW_W-1];
                dvs_reg     <= den_pos ? den_reg[DVS_W-1:0] : DVS_W'(1);
                mul_cnt_reg <= '0;
            end
            S_MUL:
            begin
                pn_reg      <= mul_step(pn_reg, mcn_reg);
                pe_reg      <= mul_step(pe_reg, mce_reg);
                mul_cnt_reg <= mul_cnt_reg + MUL_CNT_W'(1);
            end
            S_DIV:
            begin
                if (rsp_n.done)
                begin
                    qn_reg <= sgn_n_reg ? $signed(qneg_n) : $signed(qmag_n);
                    qe_reg <= sgn_e_reg ? $signed(qneg_e) : $signed(qmag_e);
                end
            end
            S_FIN:
            begin
                res_n_reg <= sat_wind(sum_n);
                res_e_reg <= sat_wind(sum_e);
            end
            default: ;
        endcase

        // Output register, loaded when the previous beat has gone.
        if (out_load)
        begin
            wind_n_reg      <= res_n_reg;
            wind_e_reg      <= res_e_reg;
            table_ready_reg <= res_rdy_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign wind_n      = wind_n_reg;
    assign wind_e      = wind_e_reg;
    assign table_ready = table_ready_reg;

endmodule

// ===== hdl/tti_chk.sv =====
// Port-level checker for the table time interpolator, bound to the top level.
// Depends on tti_pkg and on the port list of table_time_interpolator.
module tti_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic        [tti_pkg::REQ_W-1:0]  req_type,
    input logic signed [tti_pkg::TIME_W-1:0] entry_time,
    input logic signed [tti_pkg::WIND_W-1:0] entry_wind_n,
    input logic signed [tti_pkg::WIND_W-1:0] entry_wind_e,
    input logic        [tti_pkg::QT_W-1:0]   query_time,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [tti_pkg::WIND_W-1:0] wind_n,
    input logic signed [tti_pkg::WIND_W-1:0] wind_e,
    input logic                             table_ready,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [tti_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [tti_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tti_pkg::*;

    // A stalled result beat keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wind_n) && $stable(wind_e)
                                    && $stable(table_ready))
        else $error("result beat changed while stalled");

    // A query on a table that is not ready reports calm air.
    a_zero_wind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !table_ready |-> (wind_n == '0) && (wind_e == '0))
        else $error("nonzero wind with table not ready");

    // A query occupies the block: no new beat is taken in the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == REQ_QUERY) |=> !in_ready)
        else $error("input taken right after a query");

    // A result appears only while a query is in progress.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result beat without a query in progress");

endmodule

bind table_time_interpolator tti_chk u_tti_chk (.*);
